// ===== design/blwh_pkg.sv =====
// shared types and constants for the bounded-waiting lock hand-off block
// no dependencies; imported by the controller, datapath and top level
`default_nettype none
package blwh_pkg;

   // word layout on the request and response streams
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 8;
   localparam int WHO_W       = 4;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // request word accepted this cycle
      logic scan_step;  // examine one waiting bit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;     // response register can take a word
      logic req_release;  // incoming word is an in-range release
      logic hit;          // current scan slot is waiting
      logic last;         // current scan slot is the final one
   } status_type;

endpackage
`default_nettype wire

// ===== design/blwh_ctrl.sv =====
// controller for the lock hand-off block: idle / scan state machine
// depends on blwh_pkg for the state, command and status types
`default_nettype none
module blwh_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  blwh_pkg::status_type  status,
   output blwh_pkg::cmd_type     cmd
);
   import blwh_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.out_free && status.req_release) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit || status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.load_req  = 1'b0;
      cmd.scan_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = status.out_free;
            cmd.load_req = req_tvalid && status.out_free;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/blwh_dp.sv =====
// datapath for the lock hand-off block: lock flag, waiting bits, scan
// pointer and response register; depends on blwh_pkg
`default_nettype none
module blwh_dp #(
   parameter int NUM_REQUESTERS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire [blwh_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [blwh_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  blwh_pkg::cmd_type                  cmd,
   output blwh_pkg::status_type               status
);
   import blwh_pkg::*;

   localparam int IDX_W = $clog2(NUM_REQUESTERS);
   localparam int EXT_W = IDX_W + WHO_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REQUESTERS - 1);

   logic                      lock_held_ff, lock_held_in;
   logic [NUM_REQUESTERS-1:0] waiting_ff, waiting_in;
   logic [IDX_W-1:0]          scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]          scan_cnt_ff, scan_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic             req_op;
   logic [WHO_W-1:0] req_who;
   logic [EXT_W-1:0] who_ext;
   logic [IDX_W-1:0] who_idx;
   logic             who_ok;
   logic [EXT_W-1:0] holder_ext;
   logic [WHO_W-1:0] holder;

   // word fields, lowest bit first: op, requester
   assign req_op  = req_tdata[0];
   assign req_who = req_tdata[WHO_W:1];
   assign who_ext = {{IDX_W{1'b0}}, req_who};
   assign who_idx = who_ext[IDX_W-1:0];
   assign who_ok  = who_ext < EXT_W'(NUM_REQUESTERS);

   assign holder_ext = {{WHO_W{1'b0}}, scan_idx_ff};
   assign holder     = holder_ext[WHO_W-1:0];

   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign status.req_release = who_ok && (req_op == OP_RELEASE);
   assign status.hit         = waiting_ff[scan_idx_ff];
   assign status.last        = scan_cnt_ff == LAST_IDX;

   always_comb begin
      lock_held_in = lock_held_ff;
      waiting_in   = waiting_ff;
      scan_idx_in  = scan_idx_ff;
      scan_cnt_in  = scan_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load_req) begin
         // scan starts just after the releaser and wraps
         scan_idx_in = (who_idx == LAST_IDX) ? '0 : who_idx + 1'b1;
         scan_cnt_in = IDX_W'(1);
         if (!status.req_release) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            if (who_ok) begin
               if (!lock_held_ff) begin
                  lock_held_in   = 1'b1;
                  rsp_data_in[0] = 1'b1;
               end else begin
                  waiting_in[who_idx] = 1'b1;
               end
            end
            rsp_data_in[6] = who_ok ? 1'b1 : lock_held_ff;
         end
      end

      if (cmd.scan_step) begin
         if (status.hit) begin
            waiting_in[scan_idx_ff] = 1'b0;
            lock_held_in            = 1'b1;
            rsp_valid_in            = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in[1]          = 1'b1;
            rsp_data_in[5:2]        = holder;
            rsp_data_in[6]          = 1'b1;
         end else if (status.last) begin
            lock_held_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
         end else begin
            scan_idx_in = (scan_idx_ff == LAST_IDX) ? '0 : scan_idx_ff + 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_held_ff <= 1'b0;
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lock_held_ff <= lock_held_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      scan_cnt_ff <= scan_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== design/bounded_waiting_lock_handoff.sv =====
// bounded-waiting lock: acquire gets a free lock or sets a waiting bit,
// release hands the lock to the next waiter in cyclic order.
// an acquire's response word is registered in the cycle after accept; a release
// runs a scan, one waiting bit examined per cycle, before its response word.
// one word in flight at a time; next word accepted once the response is taken.
// synchronous reset frees the lock and clears all waiting bits at once.
`default_nettype none
module bounded_waiting_lock_handoff #(
   parameter int NUM_REQUESTERS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [blwh_pkg::REQ_TDATA_W-1:0]   req_tdata,  // op, requester[3:0], pad
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [blwh_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // granted_now, handed_off,
                                                         // new_holder[3:0], lock_busy, pad
);
   import blwh_pkg::*;

   cmd_type    cmd;
   status_type status;

   blwh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   blwh_dp #(
      .NUM_REQUESTERS (NUM_REQUESTERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

// ===== design/blwh_checker.sv =====
// port-level checks for the lock hand-off block, bound to the top level
// depends on blwh_pkg for the word widths
`default_nettype none
module blwh_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [blwh_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import blwh_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // no new request taken while a response is stuck
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("request accepted while response stalled");

   a_grant_xor_handoff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("grant and hand-off in one word");

   a_owner_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[0] || rsp_tdata[1]) |-> rsp_tdata[6])
      else $error("lock reported free after grant or hand-off");

   a_holder_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[5:2] == 4'd0)
      else $error("new holder nonzero without hand-off");

endmodule

bind bounded_waiting_lock_handoff blwh_checker u_blwh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
